### src/csb_pkg.sv
// Package for the per-channel scale and bias block: codes, constants,
// pipeline stage records and the leading-zero count helper.
// No dependencies; every other file in src uses it by scoped names.
package csb_pkg;

  localparam int MAX_CHANNELS_DEF = 1024;
  // width of channel counts, large enough for channel counts below 2**17
  localparam int CNT_W = 17;
  localparam int SPAT_W = 24;
  localparam int WIN_W = 76;
  localparam int EXP_W = 12;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_SPATIAL_COUNT = 3'd1,
    REG_SOURCE_BF16   = 3'd2,
    REG_DEST_BF16     = 3'd3,
    REG_LAYOUT_NHWC   = 3'd4,
    REG_APPLY_SCALE   = 3'd5,
    REG_APPLY_BIAS    = 3'd6
  } reg_idx_t;

  localparam logic [31:0] F32_ONE      = 32'h3F80_0000;
  localparam logic [31:0] F32_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] F32_QNAN     = 32'h7FC0_0000;
  localparam logic [30:0] F32_INF_MAG  = 31'h7F80_0000;

  typedef struct packed {
    logic apply_scale;
    logic apply_bias;
    logic dest_bf16;
  } csb_ctrl_t;

  // operand classification carried down the arithmetic pipeline
  typedef struct packed {
    logic        pass;
    logic        nan;
    logic        inf;
    logic        inf_sign;
    logic        prod_zero;
    logic        c_zero;
    logic        sp;
    logic        sc;
    logic [31:0] x;
    logic [31:0] c;
    logic        last;
  } csb_flags_t;

  typedef struct packed {
    csb_flags_t              f;
    logic [47:0]             mp;
    logic signed [EXP_W-1:0] lp;
    logic signed [EXP_W-1:0] lc;
    logic [23:0]             mc;
  } csb_prod_t;

  typedef struct packed {
    csb_flags_t              f;
    logic [WIN_W-1:0]        m;
    logic                    s;
    logic signed [EXP_W-1:0] lw;
  } csb_sum_t;

  typedef struct packed {
    csb_flags_t              f;
    logic [WIN_W-1:0]        n;
    logic                    s;
    logic                    mzero;
    logic signed [EXP_W-1:0] top;
  } csb_norm_t;

  function automatic logic [6:0] lzc76(input logic [WIN_W-1:0] v);
    logic [6:0] n;
    n = 7'(WIN_W);
    for (int i = 0; i < WIN_W; i++) begin
      if (v[i]) n = 7'(WIN_W - 1 - i);
    end
    return n;
  endfunction

endpackage

### src/csb_coef_ram.sv
// Coefficient store: one word of scale and bias per channel.
// Single write port, one registered read port; uses csb_pkg.
module csb_coef_ram #(
  parameter int DEPTH = csb_pkg::MAX_CHANNELS_DEF,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/csb_fma_pipe.sv
// Float32 fused multiply-add pipeline with single rounding to nearest even,
// followed by optional bfloat16 packing. Four stages; uses csb_pkg.
module csb_fma_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [31:0]       x,
  input  logic [31:0]       s_w,
  input  logic [31:0]       b_w,
  input  logic              last,
  input  csb_pkg::csb_ctrl_t ctrl,
  output logic              res_vld,
  output logic [31:0]       res_bits,
  output logic              res_last
);

  logic v2_r, v3_r, v4_r, v5_r;
  csb_pkg::csb_prod_t s2_r, s2_nxt, s3_r, s3_nxt;
  csb_pkg::csb_sum_t  s4_r, s4_nxt;
  csb_pkg::csb_norm_t s5_r, s5_nxt;

  // ---- stage 1: unpack, classify, multiply significands
  logic [31:0] a, b, c;
  logic [7:0]  ea, eb, ec, eae, ebe, ece;
  logic [23:0] ma, mb, mc;
  logic        a_inf, b_inf, c_inf, a_nan, b_nan, c_nan, a_z, b_z, c_z, sp;

  always_comb begin
    a = x;
    b = ctrl.apply_scale ? s_w : csb_pkg::F32_ONE;
    c = ctrl.apply_bias  ? b_w : csb_pkg::F32_NEG_ZERO;
    ea = a[30:23]; eb = b[30:23]; ec = c[30:23];
    eae = (ea == 8'd0) ? 8'd1 : ea;
    ebe = (eb == 8'd0) ? 8'd1 : eb;
    ece = (ec == 8'd0) ? 8'd1 : ec;
    ma = {|ea, a[22:0]}; mb = {|eb, b[22:0]}; mc = {|ec, c[22:0]};
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    c_inf = (ec == 8'hFF) && (c[22:0] == 23'd0);
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    c_nan = (ec == 8'hFF) && (c[22:0] != 23'd0);
    a_z = (a[30:0] == 31'd0);
    b_z = (b[30:0] == 31'd0);
    c_z = (c[30:0] == 31'd0);
    sp = a[31] ^ b[31];

    s2_nxt.f.pass      = !(ctrl.apply_scale || ctrl.apply_bias);
    s2_nxt.f.nan       = a_nan || b_nan || c_nan || (a_inf && b_z) || (b_inf && a_z) ||
                         ((a_inf || b_inf) && c_inf && (sp != c[31]));
    s2_nxt.f.inf       = a_inf || b_inf || c_inf;
    s2_nxt.f.inf_sign  = (a_inf || b_inf) ? sp : c[31];
    s2_nxt.f.prod_zero = a_z || b_z;
    s2_nxt.f.c_zero    = c_z;
    s2_nxt.f.sp        = sp;
    s2_nxt.f.sc        = c[31];
    s2_nxt.f.x         = x;
    s2_nxt.f.c         = c;
    s2_nxt.f.last      = last;
    s2_nxt.mp = {24'd0, ma} * {24'd0, mb};
    s2_nxt.lp = $signed({4'd0, eae}) + $signed({4'd0, ebe}) - 12'sd300;
    s2_nxt.lc = $signed({4'd0, ece}) - 12'sd150;
    s2_nxt.mc = mc;
  end

  // ---- stage 2: normalise the product
  logic [6:0] plz_full;
  logic [5:0] plz;

  always_comb begin
    plz_full = csb_pkg::lzc76({s2_r.mp, 28'd0});
    plz = plz_full[5:0];
    s3_nxt = s2_r;
    s3_nxt.mp = s2_r.mp << plz;
    s3_nxt.lp = s2_r.lp - $signed({6'd0, plz});
  end

  // ---- stage 3: align addend into the window, signed-magnitude add
  logic signed [csb_pkg::EXP_W-1:0] pos, npos;
  logic [csb_pkg::WIN_W-1:0] pw, cw;
  logic [5:0]  shl;
  logic [4:0]  shr;
  logic [23:0] chi, cmask;
  logic        cstk;

  always_comb begin
    pos   = s3_r.lc - s3_r.lp;
    npos  = -pos;
    shl   = pos[5:0] + 6'd1;
    shr   = (npos > 12'sd24) ? 5'd24 : npos[4:0];
    chi   = s3_r.mc >> shr;
    cmask = ~(24'hFF_FFFF << shr);
    cstk  = |(s3_r.mc & cmask);
    pw = {27'd0, s3_r.mp, 1'b0};
    cw = '0;
    s4_nxt.lw = s3_r.lp;
    priority if (s3_r.f.c_zero) begin
      cw = '0;
    end else if (pos > 12'sd50) begin
      // product collapses to a sticky bit below the addend
      cw = {1'b0, s3_r.mc, 51'd0};
      pw = 76'd1;
      s4_nxt.lw = s3_r.lc - 12'sd50;
    end else if (pos >= 12'sd0) begin
      cw = {52'd0, s3_r.mc} << shl;
    end else begin
      cw = {51'd0, chi, cstk};
    end
    s4_nxt.f = s3_r.f;
    priority if (s3_r.f.sp == s3_r.f.sc) begin
      s4_nxt.m = pw + cw;
      s4_nxt.s = s3_r.f.sp;
    end else if (pw >= cw) begin
      s4_nxt.m = pw - cw;
      s4_nxt.s = s3_r.f.sp;
    end else begin
      s4_nxt.m = cw - pw;
      s4_nxt.s = s3_r.f.sc;
    end
  end

  // ---- stage 4: normalise the sum
  logic [6:0] slz;

  always_comb begin
    slz = csb_pkg::lzc76(s4_r.m);
    s5_nxt.f     = s4_r.f;
    s5_nxt.n     = s4_r.m << slz;
    s5_nxt.s     = s4_r.s;
    s5_nxt.mzero = (s4_r.m == '0);
    s5_nxt.top   = s4_r.lw + 12'sd74 - $signed({5'd0, slz});
  end

  // ---- stage 5: denormal shift, round, pack, convert
  logic signed [csb_pkg::EXP_W-1:0] ebias, dsh;
  logic        normal, ovf, g, st, ext, inc;
  logic [6:0]  dcl;
  logic [csb_pkg::WIN_W-1:0] nd, sel;
  logic [7:0]  efield;
  logic [30:0] packed_mag;
  logic [31:0] f32, rbf;

  always_comb begin
    ebias  = s5_r.top + 12'sd127;
    normal = (s5_r.top >= -12'sd126);
    ovf    = normal && (ebias >= 12'sd255);
    dsh    = -12'sd126 - s5_r.top;
    dcl    = (dsh > 12'sd76) ? 7'd76 : dsh[6:0];
    nd     = s5_r.n >> dcl;
    ext    = |(s5_r.n & ~({csb_pkg::WIN_W{1'b1}} << dcl));
    sel    = normal ? s5_r.n : nd;
    g      = sel[51];
    st     = (|sel[50:0]) || (!normal && ext);
    inc    = g && (st || sel[52]);
    efield = normal ? ebias[7:0] : 8'd0;
    packed_mag = {efield, sel[74:52]} + {30'd0, inc};
    priority if (s5_r.f.pass) begin
      f32 = s5_r.f.x;
    end else if (s5_r.f.nan) begin
      f32 = csb_pkg::F32_QNAN;
    end else if (s5_r.f.inf) begin
      f32 = {s5_r.f.inf_sign, csb_pkg::F32_INF_MAG};
    end else if (s5_r.f.prod_zero) begin
      f32 = s5_r.f.c_zero ? {s5_r.f.sp & s5_r.f.sc, 31'd0} : s5_r.f.c;
    end else if (s5_r.mzero) begin
      f32 = 32'd0;
    end else if (ovf) begin
      f32 = {s5_r.s, csb_pkg::F32_INF_MAG};
    end else begin
      f32 = {s5_r.s, packed_mag};
    end
    rbf = f32 + {31'd0, f32[16]} + 32'h0000_7FFF;
  end

  assign res_vld  = v5_r;
  assign res_bits = ctrl.dest_bf16 ? {16'd0, rbf[31:16]} : f32;
  assign res_last = s5_r.f.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
    end else if (en) begin
      v2_r <= in_vld; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt; s3_r <= s3_nxt; s4_r <= s4_nxt; s5_r <= s5_nxt;
    end
  end

endmodule

### src/channel_scale_bias_bf16_unit.sv
// Top level of the per-channel scale and bias block: configuration
// registers, position counters, coefficient store and result register.
// Depends on csb_pkg, csb_coef_ram and csb_fma_pipe.
//
//  channel  direction  handshake             payload
//  in_      in         in_valid / in_ready   cmd, load_channel, scale/bias words, element
//  out_     out        out_valid / out_ready result_bits, last_element
//  config   in         psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle while the result register can move; an element taken
// passes the coefficient read, four arithmetic stages and the result register.
// Every stage advances together whenever the result register is empty or
// being taken, and in_ready is high exactly then. Load transactions give no result.
// Synchronous active-low reset clears control state; the tables hold garbage
// until loaded and no clearing pass is run.
module channel_scale_bias_bf16_unit #(
  parameter int MAX_CHANNELS = csb_pkg::MAX_CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [9:0]  in_load_channel,
  input  logic [31:0] in_scale_word,
  input  logic [31:0] in_bias_word,
  input  logic [31:0] in_element_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result_bits,
  output logic        out_last_element,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CW = csb_pkg::CNT_W;
  localparam int SW = csb_pkg::SPAT_W;

  logic [10:0]   ccount_r;
  logic [SW:0]   scount_r;
  logic          src_bf16_r, dst_bf16_r, nhwc_r, apply_scale_r, apply_bias_r;
  logic [AW-1:0] chan_pos_r, chan_pos_nxt;
  logic [SW-1:0] spat_pos_r, spat_pos_nxt;

  logic          en, in_acc, data_acc, cfg_we, geo_wr;
  logic [CW-1:0] nc_eff, cc_ext, chan_inc, ld_ext;
  logic [SW:0]   ns_eff, spat_inc;
  logic          inner_wrap, outer_wrap, ld_ok;

  logic          v1_r;
  logic [31:0]   x1_r;
  logic          last1_r;
  logic [63:0]   coef;

  logic          fma_vld, fma_last;
  logic [31:0]   fma_bits;
  csb_pkg::csb_ctrl_t ctrl;

  logic          out_valid_r, out_last_r;
  logic [31:0]   out_bits_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;
  assign in_acc   = in_valid && en;
  assign data_acc = in_acc && (in_cmd == csb_pkg::CMD_DATA);
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;

  // effective counts
  always_comb begin
    cc_ext = {6'd0, ccount_r};
    priority if (cc_ext == '0) nc_eff = CW'(1);
    else if (cc_ext > CW'(MAX_CHANNELS)) nc_eff = CW'(MAX_CHANNELS);
    else nc_eff = cc_ext;
    priority if (scount_r == '0) ns_eff = (SW+1)'(1);
    else if (scount_r > ((SW+1)'(1) << SW)) ns_eff = (SW+1)'(1) << SW;
    else ns_eff = scount_r;
  end

  // position counters
  always_comb begin
    chan_inc = CW'(chan_pos_r) + CW'(1);
    spat_inc = {1'b0, spat_pos_r} + (SW+1)'(1);
    chan_pos_nxt = chan_pos_r;
    spat_pos_nxt = spat_pos_r;
    if (nhwc_r) begin
      inner_wrap = chan_inc >= nc_eff;
      outer_wrap = inner_wrap && (spat_inc >= ns_eff);
      chan_pos_nxt = inner_wrap ? '0 : chan_inc[AW-1:0];
      if (inner_wrap) spat_pos_nxt = outer_wrap ? '0 : spat_inc[SW-1:0];
    end else begin
      inner_wrap = spat_inc >= ns_eff;
      outer_wrap = inner_wrap && (chan_inc >= nc_eff);
      spat_pos_nxt = inner_wrap ? '0 : spat_inc[SW-1:0];
      if (inner_wrap) chan_pos_nxt = outer_wrap ? '0 : chan_inc[AW-1:0];
    end
  end

  assign geo_wr = cfg_we && ((paddr[4:2] == csb_pkg::REG_CHANNEL_COUNT) ||
                             (paddr[4:2] == csb_pkg::REG_SPATIAL_COUNT) ||
                             (paddr[4:2] == csb_pkg::REG_LAYOUT_NHWC));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccount_r      <= 11'd1;
      scount_r      <= (SW+1)'(1);
      src_bf16_r    <= 1'b0;
      dst_bf16_r    <= 1'b0;
      nhwc_r        <= 1'b0;
      apply_scale_r <= 1'b1;
      apply_bias_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        csb_pkg::REG_CHANNEL_COUNT: ccount_r      <= pwdata[10:0];
        csb_pkg::REG_SPATIAL_COUNT: scount_r      <= pwdata[SW:0];
        csb_pkg::REG_SOURCE_BF16:   src_bf16_r    <= pwdata[0];
        csb_pkg::REG_DEST_BF16:     dst_bf16_r    <= pwdata[0];
        csb_pkg::REG_LAYOUT_NHWC:   nhwc_r        <= pwdata[0];
        csb_pkg::REG_APPLY_SCALE:   apply_scale_r <= pwdata[0];
        csb_pkg::REG_APPLY_BIAS:    apply_bias_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_pos_r <= '0;
      spat_pos_r <= '0;
    end else if (geo_wr) begin
      chan_pos_r <= '0;
      spat_pos_r <= '0;
    end else if (data_acc) begin
      chan_pos_r <= chan_pos_nxt;
      spat_pos_r <= spat_pos_nxt;
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      csb_pkg::REG_CHANNEL_COUNT: prdata = {21'd0, ccount_r};
      csb_pkg::REG_SPATIAL_COUNT: prdata = {7'd0, scount_r};
      csb_pkg::REG_SOURCE_BF16:   prdata = {31'd0, src_bf16_r};
      csb_pkg::REG_DEST_BF16:     prdata = {31'd0, dst_bf16_r};
      csb_pkg::REG_LAYOUT_NHWC:   prdata = {31'd0, nhwc_r};
      csb_pkg::REG_APPLY_SCALE:   prdata = {31'd0, apply_scale_r};
      csb_pkg::REG_APPLY_BIAS:    prdata = {31'd0, apply_bias_r};
      default:                    prdata = 32'd0;
    endcase
  end

  // drop loads aimed beyond the table
  assign ld_ext = {7'd0, in_load_channel};
  assign ld_ok  = ld_ext < CW'(MAX_CHANNELS);

  csb_coef_ram #(
    .DEPTH(MAX_CHANNELS),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (in_acc && (in_cmd == csb_pkg::CMD_LOAD) && ld_ok),
    .waddr(ld_ext[AW-1:0]),
    .wdata({in_scale_word, in_bias_word}),
    .re   (en),
    .raddr(chan_pos_r),
    .rdata(coef)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= data_acc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= src_bf16_r ? {in_element_bits[15:0], 16'd0} : in_element_bits;
      last1_r <= outer_wrap;
    end
  end

  assign ctrl.apply_scale = apply_scale_r;
  assign ctrl.apply_bias  = apply_bias_r;
  assign ctrl.dest_bf16   = dst_bf16_r;

  csb_fma_pipe u_fma (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v1_r),
    .x       (x1_r),
    .s_w     (coef[63:32]),
    .b_w     (coef[31:0]),
    .last    (last1_r),
    .ctrl    (ctrl),
    .res_vld (fma_vld),
    .res_bits(fma_bits),
    .res_last(fma_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= fma_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bits_r <= fma_bits;
      out_last_r <= fma_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_bits  = out_bits_r;
  assign out_last_element = out_last_r;

`ifndef SYNTHESIS
  a_chan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(chan_pos_r) < nc_eff)
    else $error("channel position beyond channel count");

  a_spat_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, spat_pos_r} < ns_eff)
    else $error("spatial position beyond spatial count");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_cmd == csb_pkg::CMD_LOAD)) |=> !v1_r)
    else $error("load transaction entered the arithmetic pipeline");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (data_acc && outer_wrap) |=> (chan_pos_r == '0) && (spat_pos_r == '0))
    else $error("counters not back at origin after last element");
`endif

endmodule

### test/channel_scale_bias_bf16_unit_tb.sv
// Testbench for channel_scale_bias_bf16_unit: streams coefficient loads and
// tensor elements and checks every result against an exact float32 predictor.
// Depends on csb_pkg and the block's RTL only.
`timescale 1ns / 100ps

module channel_scale_bias_bf16_unit_tb;

  localparam int NCH       = 1024;
  // channels loaded up front; no tensor below reaches past them
  localparam int LOADED_CH = 128;
  localparam int IDLE_MAX  = 3000;
  localparam int FXW       = 600;
  localparam int FXOFF     = 298;

  typedef struct packed {
    logic [31:0] bits;
    logic        last;
  } scaled_elem_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid, in_ready, in_cmd;
  logic [9:0]  in_load_channel;
  logic [31:0] in_scale_word, in_bias_word, in_element_bits;
  logic        out_valid, out_ready, out_last_element;
  logic [31:0] out_result_bits;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;

  // mirrored block state
  logic [31:0] scale_mem [NCH];
  logic [31:0] bias_mem [NCH];
  int unsigned chan_pos, spat_pos;
  int unsigned cfg_chans, cfg_spatial;
  logic        cfg_src_bf16, cfg_dst_bf16, cfg_nhwc, cfg_scale, cfg_bias;

  scaled_elem_t pending_results[$];
  int          results_checked, mismatches, elements_sent, loads_sent, tensors_done;
  int          idle_cycles;
  bit          send_quiet, recv_quiet, hold_req;

  always #2 clk = ~clk;

  channel_scale_bias_bf16_unit dut (.*);

  // exact a*b+c, rounded once to float32 (round to nearest even)
  function automatic logic [31:0] fused_f32(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    logic [FXW-1:0] pm, cm, mag, lowmask;
    logic [47:0]    prod;
    logic [24:0]    mant;
    logic [23:0]    ma, mb, mc;
    int             ea, eb, ec, msb, lsb, field;
    logic           psign, rsign, a_nan, b_nan, c_nan, a_inf, b_inf, c_inf;
    logic           a_zero, b_zero, guard, sticky;
    a_nan = a[30:23] == 8'hFF && a[22:0] != 0;
    b_nan = b[30:23] == 8'hFF && b[22:0] != 0;
    c_nan = c[30:23] == 8'hFF && c[22:0] != 0;
    a_inf = a[30:0] == csb_pkg::F32_INF_MAG;
    b_inf = b[30:0] == csb_pkg::F32_INF_MAG;
    c_inf = c[30:0] == csb_pkg::F32_INF_MAG;
    a_zero = a[30:0] == 0;
    b_zero = b[30:0] == 0;
    psign = a[31] ^ b[31];
    if (a_nan || b_nan || c_nan) return csb_pkg::F32_QNAN;
    if ((a_inf && b_zero) || (b_inf && a_zero)) return csb_pkg::F32_QNAN;
    if ((a_inf || b_inf) && c_inf && psign != c[31]) return csb_pkg::F32_QNAN;
    if (a_inf || b_inf) return {psign, csb_pkg::F32_INF_MAG};
    if (c_inf) return c;
    ma = a[30:23] == 0 ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    mb = b[30:23] == 0 ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
    mc = c[30:23] == 0 ? {1'b0, c[22:0]} : {1'b1, c[22:0]};
    ea = a[30:23] == 0 ? -149 : int'(a[30:23]) - 150;
    eb = b[30:23] == 0 ? -149 : int'(b[30:23]) - 150;
    ec = c[30:23] == 0 ? -149 : int'(c[30:23]) - 150;
    prod = ma * mb;
    pm = FXW'(prod) << (ea + eb + FXOFF);
    cm = FXW'(mc) << (ec + FXOFF);
    if (pm == 0 && cm == 0) return {psign & c[31], 31'b0};
    if (psign == c[31]) begin
      mag = pm + cm;
      rsign = psign;
    end else if (pm >= cm) begin
      mag = pm - cm;
      rsign = psign;
    end else begin
      mag = cm - pm;
      rsign = c[31];
    end
    if (mag == 0) return 32'b0;
    msb = 0;
    for (int i = 0; i < FXW; i++) if (mag[i]) msb = i;
    lsb = msb - 23 > 149 ? msb - 23 : 149;
    mant = 25'(mag >> lsb);
    guard = mag[lsb-1];
    lowmask = (FXW'(1) << (lsb - 1)) - 1;
    sticky = (mag & lowmask) != 0;
    if (guard && (sticky || mant[0])) mant = mant + 1;
    if (mant[24]) begin
      mant = mant >> 1;
      lsb++;
    end
    field = mant[23] ? lsb - 148 : 0;
    if (field >= 255) return {rsign, csb_pkg::F32_INF_MAG};
    return {rsign, 8'(field), mant[22:0]};
  endfunction

  function automatic scaled_elem_t predict_element(input logic [31:0] elem);
    scaled_elem_t r;
    logic [31:0]  x, rnd;
    int unsigned  ch, nc, ns;
    logic         inner, outer;
    nc = cfg_chans == 0 ? 1 : (cfg_chans > NCH ? NCH : cfg_chans);
    ns = cfg_spatial == 0 ? 1 : (cfg_spatial > 32'h100_0000 ? 32'h100_0000 : cfg_spatial);
    ch = chan_pos % NCH;
    x = cfg_src_bf16 ? {elem[15:0], 16'h0} : elem;
    if (cfg_scale && cfg_bias) x = fused_f32(x, scale_mem[ch], bias_mem[ch]);
    else if (cfg_scale) x = fused_f32(x, scale_mem[ch], csb_pkg::F32_NEG_ZERO);
    else if (cfg_bias) x = fused_f32(x, csb_pkg::F32_ONE, bias_mem[ch]);
    rnd = 32'(x[16]) + 32'h7FFF;
    r.bits = cfg_dst_bf16 ? {16'h0, 16'((x + rnd) >> 16)} : x;
    if (cfg_nhwc) begin
      inner = chan_pos + 1 >= nc;
      outer = inner && spat_pos + 1 >= ns;
      chan_pos = inner ? 0 : chan_pos + 1;
      if (inner) spat_pos = outer ? 0 : spat_pos + 1;
    end else begin
      inner = spat_pos + 1 >= ns;
      outer = inner && chan_pos + 1 >= nc;
      spat_pos = inner ? 0 : spat_pos + 1;
      if (inner) chan_pos = outer ? 0 : chan_pos + 1;
    end
    r.last = outer;
    return r;
  endfunction

  // mostly finite values of moderate size, with specials and raw noise
  function automatic logic [31:0] pick_f32();
    logic [31:0] specials [8] = '{32'h0, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                  32'h7FC0_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'h807F_FFFF};
    unique case ($urandom_range(0, 7))
      0: return $urandom;
      1: return specials[$urandom_range(0, 7)];
      2: return {1'($urandom), 8'($urandom_range(1, 254)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_item(input logic cmd, input logic [9:0] chan, input logic [31:0] sw,
                           input logic [31:0] bw, input logic [31:0] elem);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_load_channel <= chan;
    in_scale_word <= sw;
    in_bias_word <= bw;
    in_element_bits <= elem;
    do @(posedge clk); while (!in_ready);
    if (cmd == csb_pkg::CMD_DATA) begin
      pending_results.push_back(predict_element(elem));
      elements_sent++;
    end else begin
      scale_mem[chan] = sw;
      bias_mem[chan] = bw;
      loads_sent++;
    end
  endtask

  task automatic send_element(input logic [31:0] elem);
    send_item(csb_pkg::CMD_DATA, 10'($urandom), $urandom, $urandom, elem);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input csb_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    unique case (idx)
      csb_pkg::REG_CHANNEL_COUNT: cfg_chans = value[10:0];
      csb_pkg::REG_SPATIAL_COUNT: cfg_spatial = value[24:0];
      csb_pkg::REG_SOURCE_BF16:   cfg_src_bf16 = value[0];
      csb_pkg::REG_DEST_BF16:     cfg_dst_bf16 = value[0];
      csb_pkg::REG_LAYOUT_NHWC:   cfg_nhwc = value[0];
      csb_pkg::REG_APPLY_SCALE:   cfg_scale = value[0];
      csb_pkg::REG_APPLY_BIAS:    cfg_bias = value[0];
      default: ;
    endcase
    if (idx inside {csb_pkg::REG_CHANNEL_COUNT, csb_pkg::REG_SPATIAL_COUNT,
                    csb_pkg::REG_LAYOUT_NHWC}) begin
      chan_pos = 0;
      spat_pos = 0;
    end
    // leave the bus idle before the next write
    @(posedge clk);
  endtask

  task automatic configure(input int unsigned chans, input int unsigned spatial,
                           input logic src16, input logic dst16, input logic nhwc,
                           input logic scl, input logic bia);
    wait_drained();
    write_reg(csb_pkg::REG_CHANNEL_COUNT, chans);
    write_reg(csb_pkg::REG_SPATIAL_COUNT, spatial);
    write_reg(csb_pkg::REG_SOURCE_BF16, {31'($urandom), src16});
    write_reg(csb_pkg::REG_DEST_BF16, {31'($urandom), dst16});
    write_reg(csb_pkg::REG_LAYOUT_NHWC, {31'($urandom), nhwc});
    write_reg(csb_pkg::REG_APPLY_SCALE, {31'($urandom), scl});
    write_reg(csb_pkg::REG_APPLY_BIAS, {31'($urandom), bia});
  endtask

  // load the low channels once so no element ever reads garbage
  task automatic test_load_all_channels();
    send_quiet = 1'b1;
    for (int i = 0; i < LOADED_CH; i++)
      send_item(csb_pkg::CMD_LOAD, 10'(i), pick_f32(), pick_f32(), 32'h0);
  endtask

  task automatic test_directed_extremes();
    logic [31:0] vals [10] = '{32'h0, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                               32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h3F80_0000,
                               32'h0001_7FFF, 32'h0000_8000};
    send_quiet = 1'b0;
    send_item(csb_pkg::CMD_LOAD, 10'd0, 32'h4000_0000, 32'hBF80_0000, 32'h0);
    send_item(csb_pkg::CMD_LOAD, 10'd1023, 32'h7F7F_FFFF, 32'h7F80_0000, 32'h0);
    for (int m = 0; m < 4; m++) begin
      configure(2, 1, m[0], m[1], m[0], m[1], m[0] | m[1] ? m[0] : 1'b0);
      for (int i = 0; i < 5; i++) send_element(vals[(m * 3 + i) % 10]);
    end
    // neither scale nor bias: plain format conversion
    configure(1, 1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) send_element(vals[i]);
  endtask

  task automatic test_count_limits();
    // zero acts as one, oversize clamps to the table depth / spatial limit
    configure(0, 0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    repeat (4) send_element(pick_f32());
    configure(2047, 33554431, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
    repeat (8) send_element(pick_f32());
    configure(1024, 16777216, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
    repeat (4) send_element(pick_f32());
    wait_drained();
    write_reg(csb_pkg::reg_idx_t'(3'd7), 32'hFFFF_FFFF);
    repeat (4) send_element(pick_f32());
    // geometry rewrite mid tensor restarts positions
    configure(3, 2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    repeat (3) send_element(pick_f32());
    wait_drained();
    write_reg(csb_pkg::REG_SPATIAL_COUNT, 2);
    repeat (7) send_element(pick_f32());
  endtask

  task automatic test_random_tensors();
    int unsigned chans, spatial;
    int          n;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0: chans = 1;
        1: chans = $urandom_range(2, 4);
        2: chans = ph == 5 ? 1024 : $urandom_range(1, 16);
        default: chans = $urandom_range(1, 8);
      endcase
      spatial = $urandom_range(0, 5) == 0 ? 1 : $urandom_range(1, 12);
      if (ph == 9) spatial = 16777216;
      configure(chans, spatial, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom));
      send_quiet = ph % 4 == 1;
      recv_quiet = ph % 4 == 2;
      if (ph == 3) hold_req = 1'b1;
      n = 90 + $urandom_range(0, 20);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(csb_pkg::CMD_LOAD, 10'($urandom), pick_f32(), pick_f32(), $urandom);
        else
          send_element(pick_f32());
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  // receiver: random stalls per result, one long hold-off on request
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      n = recv_quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    scaled_elem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", out_result_bits);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (want.last) tensors_done++;
        if (out_result_bits !== want.bits) begin
          $error("result_bits: expected %h, got %h", want.bits, out_result_bits);
          mismatches++;
        end
        if (out_last_element !== want.last) begin
          $error("last_element: expected %b, got %b", want.last, out_last_element);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = csb_pkg::CMD_LOAD;
    in_load_channel = '0;
    in_scale_word = '0;
    in_bias_word = '0;
    in_element_bits = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    chan_pos = 0;
    spat_pos = 0;
    cfg_chans = 1;
    cfg_spatial = 1;
    cfg_src_bf16 = 1'b0;
    cfg_dst_bf16 = 1'b0;
    cfg_nhwc = 1'b0;
    cfg_scale = 1'b1;
    cfg_bias = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_all_channels();
    test_directed_extremes();
    test_count_limits();
    test_random_tensors();
    wait_drained();
    $display("Sent %0d elements and %0d coefficient loads; checked %0d results.",
             elements_sent, loads_sent, results_checked);
    $display("Tensor ends seen: %0d; mismatches: %0d.", tensors_done, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
